/* rtl/bms_pkg.sv */
package bms_pkg;

    localparam int SONG_DEPTH = 1024;
    localparam int SONG_AW    = $clog2(SONG_DEPTH);
    localparam int ADDR_W     = 10;
    localparam int CMD_W      = 3;
    localparam longint unsigned CLOCK_HZ = 64'd8000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 3'd0,
        CMD_START   = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_SILENCE = 3'd3,
        CMD_CLICK   = 3'd4
    } t_cmd;

    // low nibble codes of a song byte
    localparam logic [3:0] CODE_END       = 4'hF;
    localparam logic [3:0] CODE_EXTEND    = 4'hE;
    localparam logic [3:0] CODE_PAUSE     = 4'hD;
    localparam logic [3:0] CODE_ALT_PAUSE = 4'hC;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
    } t_in_item;

    typedef struct packed {
        logic        playing;
        logic        tone_on;
        logic [15:0] compare_value;
        logic        pin_level;
    } t_out_item;

    typedef struct packed {
        logic        running;
        logic [3:0]  remaining;
        logic        tone;
        logic [15:0] divider;
        logic        level;
    } t_state;

    function automatic logic [15:0] sat16(input longint unsigned q);
        logic [15:0] r;
        r = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        return r;
    endfunction

    // divider = 4*f_clk / (f + 0.5), frequencies in centihertz
    localparam logic [15:0] NOTE_DIV [12] = '{
        sat16(CLOCK_HZ * 64'd400 / (64'd52325 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd55437 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd58733 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd62225 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd65925 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd69846 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd73999 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd78399 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd83061 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd88000 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd93233 + 64'd50)),
        sat16(CLOCK_HZ * 64'd400 / (64'd98777 + 64'd50))
    };

    function automatic logic [15:0] note_divider(input logic [3:0] note);
        logic [15:0] r;
        r = (note < 4'd12) ? NOTE_DIV[note] : 16'd0;
        return r;
    endfunction

endpackage

/* rtl/bms_in_if.sv */
interface bms_in_if;
    logic               valid;
    logic               ready;
    bms_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bms_out_if.sv */
interface bms_out_if;
    logic               valid;
    logic               ready;
    bms_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bms_ram.sv */
module bms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bms_decode.sv */
module bms_decode (
    input  logic [bms_pkg::CMD_W-1:0] i_cmd,
    input  logic [7:0]                i_byte,
    input  bms_pkg::t_state           i_cur,
    output bms_pkg::t_state           o_nxt,
    output logic                      o_adv
);

    logic           adv;
    logic [3:0]     code;
    bms_pkg::t_state nxt;
    bms_pkg::t_state dec;

    assign code = i_byte[3:0];

    // song byte decode, applied when the song moves to a new byte
    always_comb begin
        dec         = i_cur;
        dec.running = 1'b1;
        case (code) inside
            bms_pkg::CODE_END: begin
                dec.tone      = 1'b0;
                dec.level     = 1'b0;
                dec.running   = 1'b0;
                dec.remaining = 4'd0;
            end
            bms_pkg::CODE_EXTEND: begin
                dec.remaining = i_byte[7:4];
            end
            bms_pkg::CODE_PAUSE, bms_pkg::CODE_ALT_PAUSE: begin
                dec.tone      = 1'b0;
                dec.level     = 1'b0;
                dec.remaining = i_byte[7:4];
            end
            default: begin
                dec.level     = 1'b0;
                dec.tone      = 1'b1;
                dec.divider   = bms_pkg::note_divider(code) >> i_byte[7:6];
                dec.remaining = {2'b00, i_byte[5:4]};
            end
        endcase
    end

    always_comb begin
        nxt = i_cur;
        adv = 1'b0;
        unique case (i_cmd)
            bms_pkg::CMD_START: begin
                nxt = dec;
                adv = 1'b1;
            end
            bms_pkg::CMD_TICK: begin
                if (i_cur.running) begin
                    if (i_cur.remaining != 4'd0) begin
                        nxt.remaining = i_cur.remaining - 4'd1;
                    end else begin
                        nxt = dec;
                        adv = 1'b1;
                    end
                end
            end
            bms_pkg::CMD_SILENCE: begin
                nxt.tone  = 1'b0;
                nxt.level = 1'b0;
            end
            bms_pkg::CMD_CLICK: begin
                nxt.tone  = 1'b0;
                nxt.level = 1'b1;
            end
            default: begin
                nxt = i_cur;
            end
        endcase
    end

    assign o_nxt = nxt;
    assign o_adv = adv;

endmodule

/* rtl/buzzer_melody_sequencer.sv */
// Melody sequencer for a piezo buzzer. Load transfers write song bytes into an
// on-chip store; start plays from byte 0 and each tick moves the song one time
// step. Every transfer returns one result: playing flag, tone enable, the tone
// divider for the compare timer and the static pin level. Throughput is one
// transfer per clock while the output is not stalled. The song store's read
// port is registered: address in the accept stage, byte decoded in stage 2.
// The store is not cleared at reset; play only loaded bytes.
module buzzer_melody_sequencer (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bms_in_if.sink    i_in,
    bms_out_if.source o_out
);

    localparam int AW = bms_pkg::SONG_AW;

    // stage 1: accept, store access
    logic          in_fire;
    logic          is_load;
    logic          is_read;
    logic          load_ok;
    logic [AW-1:0] fwd_pos;
    logic [AW-1:0] next_pos;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_byte;

    // stage 2: decode, state update
    logic                      r_s2_valid;
    logic [bms_pkg::CMD_W-1:0] r_s2_cmd;
    logic [AW-1:0]             r_s2_addr;
    logic                      s2_fire;
    logic                      dec_adv;
    bms_pkg::t_state           dec_nxt;

    // architectural state
    bms_pkg::t_state r_state;
    logic [AW-1:0]   r_position;

    // output register
    logic               r_out_valid;
    bms_pkg::t_out_item r_out;

    assign s2_fire   = r_s2_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s2_valid || s2_fire;
    assign in_fire   = i_in.valid && i_in.ready;

    assign is_load = (i_in.payload.cmd == bms_pkg::CMD_LOAD);
    assign is_read = (i_in.payload.cmd == bms_pkg::CMD_START) ||
                     (i_in.payload.cmd == bms_pkg::CMD_TICK);
    assign load_ok = 32'(i_in.payload.address) < 32'(bms_pkg::SONG_DEPTH);

    // position forwarding: an advance still sitting in stage 2 has not
    // reached r_position yet
    assign fwd_pos  = (r_s2_valid && dec_adv) ? r_s2_addr : r_position;
    assign next_pos = (fwd_pos == AW'(bms_pkg::SONG_DEPTH - 1)) ? '0 : fwd_pos + AW'(1);
    // tick always prefetches the next byte; stage 2 uses it only on advance
    assign rd_addr  = (i_in.payload.cmd == bms_pkg::CMD_START) ? '0 : next_pos;

    bms_ram #(
        .WIDTH (8),
        .DEPTH (bms_pkg::SONG_DEPTH)
    ) u_song_store (
        .i_clk   (i_clk),
        .i_we    (in_fire && is_load && load_ok),
        .i_waddr (AW'(i_in.payload.address)),
        .i_wdata (i_in.payload.data),
        .i_re    (in_fire && is_read),
        .i_raddr (rd_addr),
        .o_rdata (rd_byte)
    );

    bms_decode u_decode (
        .i_cmd  (r_s2_cmd),
        .i_byte (rd_byte),
        .i_cur  (r_state),
        .o_nxt  (dec_nxt),
        .o_adv  (dec_adv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_position  <= '0;
            r_state     <= '0;
        end else begin
            if (in_fire) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_fire) begin
                r_state     <= dec_nxt;
                r_out_valid <= 1'b1;
                if (dec_adv) begin
                    r_position <= r_s2_addr;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s2_cmd  <= i_in.payload.cmd;
            r_s2_addr <= rd_addr;
        end
        if (s2_fire) begin
            r_out.playing       <= dec_nxt.running;
            r_out.tone_on       <= dec_nxt.tone;
            r_out.compare_value <= dec_nxt.divider;
            r_out.pin_level     <= dec_nxt.level;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`ifndef SYNTHESIS
    a_start_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && (r_s2_cmd == bms_pkg::CMD_START) |=> r_position == '0)
        else $error("start did not rewind position");

    a_silence_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && (r_s2_cmd == bms_pkg::CMD_SILENCE)
        |=> !r_out.tone_on && !r_out.pin_level && r_out_valid)
        else $error("silence left tone or pin active");

    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s2_valid)
        else $error("accepted transfer lost before decode");

    a_state_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire |=> r_out.playing == r_state.running && r_out.tone_on == r_state.tone)
        else $error("result differs from state");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    // no transfer on either channel for this many cycles ends the run
    localparam int unsigned STALL_LIMIT  = 2000;
    // cycles allowed after the last status for stray outputs to show up
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS  = 430;
    localparam int unsigned LONG_HOLD    = 120;
    localparam int unsigned SONG_STEPS   = 300;

    // command codes past CMD_CLICK; the block must leave its state alone
    localparam logic [bms_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [bms_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    // pitch of C..B in the lowest octave, in hundredths of a hertz
    localparam int unsigned PITCH_CHZ [12] = '{
        52325, 55437, 58733, 62225, 65925, 69846,
        73999, 78399, 83061, 88000, 93233, 98777
    };

    // Tracks the player state, predicts one status per command transfer and
    // checks the status stream against it in order.
    class player_scoreboard;
        logic [7:0]          song [bms_pkg::SONG_DEPTH];
        bit                  loaded [bms_pkg::SONG_DEPTH];
        int unsigned         pos;
        logic [3:0]          ticks_left;
        bit                  run;
        bit                  tone;
        logic [15:0]         divider;
        bit                  level;
        bms_pkg::t_out_item  status_q [$];
        int unsigned         errors;

        function new();
            pos        = 0;
            ticks_left = '0;
            run        = 1'b0;
            tone       = 1'b0;
            divider    = '0;
            level      = 1'b0;
            errors     = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        // 4 * f_clk / (f + 0.5), clipped to 16 bits, then one octave per shift
        function logic [15:0] tone_period(input logic [3:0] note,
                                          input logic [1:0] octave);
            longint unsigned q;
            q = bms_pkg::CLOCK_HZ * 400 / (PITCH_CHZ[note] + 50);
            if (q > 65535) q = 65535;
            return 16'(q >> octave);
        endfunction

        function void decode_byte(input logic [7:0] b);
            if (b[3:0] == bms_pkg::CODE_END) begin
                tone       = 1'b0;
                level      = 1'b0;
                run        = 1'b0;
                ticks_left = '0;
                return;
            end
            run = 1'b1;
            if (b[3:0] == bms_pkg::CODE_EXTEND) begin
                ticks_left = b[7:4];
            end else if (b[3:0] >= bms_pkg::CODE_ALT_PAUSE) begin
                // note twelve plays as a pause
                tone       = 1'b0;
                level      = 1'b0;
                ticks_left = b[7:4];
            end else begin
                level      = 1'b0;
                divider    = tone_period(b[3:0], b[7:6]);
                tone       = 1'b1;
                ticks_left = {2'b00, b[5:4]};
            end
        endfunction

        function void note_input(input bms_pkg::t_in_item it);
            bms_pkg::t_out_item r;
            case (it.cmd)
                bms_pkg::CMD_LOAD: begin
                    if (it.address < bms_pkg::SONG_DEPTH) begin
                        song[it.address]   = it.data;
                        loaded[it.address] = 1'b1;
                    end
                end
                bms_pkg::CMD_START: begin
                    pos = 0;
                    decode_byte(song[0]);
                end
                bms_pkg::CMD_TICK: begin
                    if (run) begin
                        if (ticks_left != 0) begin
                            ticks_left = ticks_left - 4'd1;
                        end else begin
                            pos = (pos + 1) % bms_pkg::SONG_DEPTH;
                            decode_byte(song[pos]);
                        end
                    end
                end
                bms_pkg::CMD_SILENCE: begin
                    tone  = 1'b0;
                    level = 1'b0;
                end
                bms_pkg::CMD_CLICK: begin
                    tone  = 1'b0;
                    level = 1'b1;
                end
                default: ;
            endcase
            r.playing       = run;
            r.tone_on       = tone;
            r.compare_value = divider;
            r.pin_level     = level;
            status_q.push_back(r);
        endfunction

        // true when cmd would make the player read a store entry never loaded
        function bit reads_unloaded(input logic [bms_pkg::CMD_W-1:0] cmd,
                                    output int unsigned slot);
            slot = 0;
            if (cmd == bms_pkg::CMD_TICK && run && ticks_left == 0) begin
                slot = (pos + 1) % bms_pkg::SONG_DEPTH;
            end else if (cmd != bms_pkg::CMD_START) begin
                return 1'b0;
            end
            return !loaded[slot];
        endfunction

        function void compare_field(input string field_name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, field_name, want, got);
            end
        endfunction

        function void check_result(input bms_pkg::t_out_item got);
            bms_pkg::t_out_item want;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: status with no command pending, expected none, got %p",
                         $time, got);
                return;
            end
            want = status_q.pop_front();
            compare_field("playing", 16'(want.playing), 16'(got.playing));
            compare_field("tone_on", 16'(want.tone_on), 16'(got.tone_on));
            compare_field("compare_value", want.compare_value, got.compare_value);
            compare_field("pin_level", 16'(want.pin_level), 16'(got.pin_level));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bms_in_if  cmd_ch ();
    bms_out_if status_ch ();

    player_scoreboard sb;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned hold_request;
    int unsigned items_sent;
    int unsigned stall_cycles;

    buzzer_melody_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (status_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // Status sink. Ready changes on the falling edge only. A hold request from
    // the stimulus keeps ready low for that many cycles, counted here.
    initial begin
        int unsigned hold_left;
        hold_left       = 0;
        status_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                status_ch.ready <= 1'b0;
            end else begin
                status_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Status check on every output transfer, plus the stall watchdog.
    always @(posedge i_clk) begin
        if (status_ch.valid && status_ch.ready) sb.check_result(status_ch.payload);
        if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // One command transfer. Entered and left on a falling edge; valid stays
    // high on return so back-to-back transfers need no gap.
    task automatic send_item(input bms_pkg::t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= it;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_input(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // The store is not cleared at reset, so a start or tick that would land on
    // an entry never loaded gets a load of that entry first.
    task automatic issue(input logic [bms_pkg::CMD_W-1:0] cmd,
                         input logic [bms_pkg::ADDR_W-1:0] addr = '0,
                         input logic [7:0] data = '0);
        bms_pkg::t_in_item it;
        int unsigned       slot;
        if (sb.reads_unloaded(cmd, slot)) begin
            it.cmd     = bms_pkg::CMD_LOAD;
            it.address = bms_pkg::ADDR_W'(slot);
            it.data    = 8'($urandom);
            send_item(it);
        end
        it.cmd     = cmd;
        it.address = addr;
        it.data    = data;
        send_item(it);
    endtask

    task automatic send_noise();
        issue(3'($urandom), 10'($urandom), 8'($urandom));
    endtask

    // Drop valid and wait for every predicted status. Always waits on a
    // falling edge so the next transfer drives valid in a fresh step.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.status_q.size() != 0);
    endtask

    function automatic logic [7:0] random_song_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(9))
            0: b[3:0] = bms_pkg::CODE_EXTEND;
            1: b[3:0] = bms_pkg::CODE_PAUSE;
            2: b[3:0] = bms_pkg::CODE_ALT_PAUSE;
            default: b[3:0] = 4'($urandom_range(11));
        endcase
        // long holds stretch a song a lot; keep most of them short
        if (b[3:0] >= bms_pkg::CODE_ALT_PAUSE && $urandom_range(3) != 0) b[7:6] = 2'b00;
        return b;
    endfunction

    // Load a short song ending in the end code, start it and tick it to the
    // end, with the odd silence, click, restart or random command mixed in.
    task automatic play_song();
        int unsigned len;
        int unsigned steps;
        len = $urandom_range(2, 8);
        for (int unsigned i = 0; i + 1 < len; i++) begin
            issue(bms_pkg::CMD_LOAD, bms_pkg::ADDR_W'(i), random_song_byte());
        end
        issue(bms_pkg::CMD_LOAD, bms_pkg::ADDR_W'(len - 1),
              {4'($urandom), bms_pkg::CODE_END});
        issue(bms_pkg::CMD_START);
        steps = 0;
        while (sb.run && steps < SONG_STEPS) begin
            case ($urandom_range(49))
                0: issue(bms_pkg::CMD_SILENCE);
                1: issue(bms_pkg::CMD_CLICK);
                2: send_noise();
                3: issue(bms_pkg::CMD_START);
                default: issue(bms_pkg::CMD_TICK);
            endcase
            steps++;
        end
        // ticks after the end code must be ignored
        repeat ($urandom_range(2)) issue(bms_pkg::CMD_TICK);
    endtask

    initial begin
        int unsigned phase_end;
        sb             = new();
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        hold_request   = 0;
        items_sent     = 0;
        stall_cycles   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling.
        issue(bms_pkg::CMD_CLICK);                 // pin level high, tone off
        issue(bms_pkg::CMD_TICK);                  // tick before start does nothing
        issue(bms_pkg::CMD_SILENCE);
        issue(CMD_SPARE_FIRST);                    // spare codes change nothing
        issue(CMD_SPARE_LAST);
        issue(bms_pkg::CMD_LOAD, '1, 8'hFF);       // top store entry, all-ones byte
        issue(bms_pkg::CMD_LOAD, '0, 8'h00);       // lowest note and octave: largest divider
        issue(bms_pkg::CMD_START);
        issue(bms_pkg::CMD_LOAD, '0, {4'h0, bms_pkg::CODE_EXTEND});
        issue(bms_pkg::CMD_START);                 // extend at start: tone stays on
        issue(bms_pkg::CMD_LOAD, 10'd1, 8'hFB);    // top note, top octave, longest length
        issue(bms_pkg::CMD_LOAD, 10'd2, {4'h1, bms_pkg::CODE_ALT_PAUSE});
        issue(bms_pkg::CMD_LOAD, 10'd3, {4'h0, bms_pkg::CODE_PAUSE});
        issue(bms_pkg::CMD_LOAD, 10'd4, {4'h3, bms_pkg::CODE_EXTEND});
        issue(bms_pkg::CMD_LOAD, 10'd5, {4'hF, bms_pkg::CODE_END});
        issue(bms_pkg::CMD_TICK);                  // into the top note
        issue(bms_pkg::CMD_CLICK);                 // click mid-song: timing goes on
        repeat (5) issue(bms_pkg::CMD_TICK);       // note runs out, note twelve pause
        issue(bms_pkg::CMD_SILENCE);
        repeat (6) issue(bms_pkg::CMD_TICK);       // pause, extend, then the end code
        wait_drained();

        // Random part in three phases, two with random idling and one with a long sink
        // hold; each phase ends with the sender paused until all status has come back.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 14;
                    snk_idle_pct = 48;
                end
                1: begin
                    src_idle_pct = 48;
                    snk_idle_pct = 14;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    // sink holds off while the sender keeps offering commands,
                    // so the block backs up and drops its input ready
                    hold_request = LONG_HOLD;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, 5)) send_noise();
                end else begin
                    play_song();
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/bms_pkg.sv
rtl/bms_in_if.sv
rtl/bms_out_if.sv
rtl/bms_ram.sv
rtl/bms_decode.sv
rtl/buzzer_melody_sequencer.sv
test/tb.sv
